FILE: hw/rtl/idba_pkg.sv
// idba_pkg: shared constants, operation codes and the scan result type
// for the rotating identifier bitmap allocator. no dependencies.
`timescale 1ns / 1ps

package idba_pkg;

  // bitmap is stored as words of this many bits
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam int NUM_IDS_DEF = 256;

  localparam int ID_W    = 8;
  localparam int COUNT_W = 9;
  localparam int MODE_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd3;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } scan_res_t;

endpackage

FILE: hw/rtl/idba_bitmap.sv
// idba_bitmap: word-wide in-use bitmap memory with per-word valid flags
// so that reset empties the pool at once. depends on idba_pkg.
`timescale 1ns / 1ps

module idba_bitmap #(
  parameter int NUM_WORDS = idba_pkg::NUM_IDS_DEF / idba_pkg::WORD_W,
  parameter int ADDR_W    = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [idba_pkg::WORD_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [idba_pkg::WORD_W-1:0] wr_data
);
  import idba_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_vld_r;
  logic [WORD_W-1:0]    rd_word_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // a word never written since reset reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        word_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= word_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

FILE: hw/rtl/idba_scan.sv
// idba_scan: masked find-first-free over one bitmap word, shared by every
// step of the circular search. depends on idba_pkg.
`timescale 1ns / 1ps

module idba_scan #(
  parameter int NUM_IDS = idba_pkg::NUM_IDS_DEF
) (
  input  logic [idba_pkg::WORD_W-1:0] word_data,
  input  logic                        last_word,
  input  logic                        first_pass,
  input  logic                        final_pass,
  input  logic [idba_pkg::BIT_W-1:0]  start_bit,
  output idba_pkg::scan_res_t         res
);
  import idba_pkg::*;

  localparam int NW    = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int LASTB = NUM_IDS - WORD_W * (NW - 1);
  localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((64'd1 << LASTB) - 64'd1);

  logic [WORD_W-1:0] pass_mask;
  logic [WORD_W-1:0] range_mask;
  logic [WORD_W-1:0] avail;

  always_comb begin
    // first visit covers bits at and above the start, the wrap-around visit the rest
    if (first_pass) begin
      pass_mask = {WORD_W{1'b1}} << start_bit;
    end else if (final_pass) begin
      pass_mask = ~({WORD_W{1'b1}} << start_bit);
    end else begin
      pass_mask = {WORD_W{1'b1}};
    end
    range_mask = last_word ? LAST_MASK : {WORD_W{1'b1}};
    avail      = ~word_data & pass_mask & range_mask;
  end

  always_comb begin
    res.found   = |avail;
    res.bit_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        res.bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/rotating_id_bitmap_allocator.sv
// rotating_id_bitmap_allocator: top level, sequencer, search pointer and
// in-use counter. depends on idba_pkg, idba_bitmap and idba_scan.
// allocate: the start cycle issues the read of the word at the search pointer, then
// S_SCAN visits one bitmap word per cycle (NW = NUM_IDS/32 rounded up, 8 by default)
// through the shared scan unit; take, release and check read their word, then pass S_GID.
// busy drops in the beat cycle; a new request is taken only once the last one is done.
// reset: synchronous rst_n empties the pool, zeroes pointer and count at once.
// the result beat is a one-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps

module rotating_id_bitmap_allocator #(
  parameter int NUM_IDS = idba_pkg::NUM_IDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [idba_pkg::MODE_W-1:0]  in_mode,
  input  logic [idba_pkg::ID_W-1:0]    in_given_id,
  output logic                         out_valid,
  output logic [idba_pkg::ID_W-1:0]    out_allocated_id,
  output logic                         out_pool_full,
  output logic                         out_id_was_taken,
  output logic [idba_pkg::COUNT_W-1:0] out_used_count
);
  import idba_pkg::*;

  // bitmap geometry
  localparam int NW     = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int WIW    = (NW > 1) ? $clog2(NW) : 1;
  localparam int STEP_W = $clog2(NW + 1);
  // ids and pointer values below this limit are inside the pool
  localparam logic [ID_W:0] LIMIT = (NUM_IDS > 256) ? 9'd256 : 9'(NUM_IDS);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_GID  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [ID_W-1:0]    gid_r, gid_nxt;
  logic               gid_ok_r, gid_ok_nxt;
  logic [BIT_W-1:0]   sb_r, sb_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [WIW-1:0]     word_r, word_nxt;
  logic [ID_W-1:0]    ptr_r, ptr_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic               out_full_r, out_full_nxt;
  logic               out_was_r, out_was_nxt;

  // bitmap memory ports
  logic              rd_en;
  logic [WIW-1:0]    rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [WIW-1:0]    wr_addr;
  logic [WORD_W-1:0] wr_data;

  scan_res_t scan_res;

  // start point and given id decode
  logic [ID_W-1:0]   start_id;
  logic [15:0]       start16;
  logic [15:0]       gid16_in;
  logic [15:0]       gid16_r;
  logic              in_gid_ok;
  logic              accept;
  logic [15:0]       found16;
  logic [15:0]       next16;
  logic [WORD_W-1:0] gid_onehot;
  logic              gid_was;
  logic [WIW-1:0]    word_inc;

  idba_bitmap #(
    .NUM_WORDS (NW),
    .ADDR_W    (WIW)
  ) u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  idba_scan #(
    .NUM_IDS (NUM_IDS)
  ) u_scan (
    .word_data  (rd_data),
    .last_word  (word_r == WIW'(NW - 1)),
    .first_pass (step_r == '0),
    .final_pass (step_r == STEP_W'(NW)),
    .start_bit  (sb_r),
    .res        (scan_res)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign start_id  = ({1'b0, ptr_r} < LIMIT) ? ptr_r : '0;
  assign start16   = 16'(start_id);
  assign gid16_in  = 16'(in_given_id);
  assign gid16_r   = 16'(gid_r);
  assign in_gid_ok = ({1'b0, in_given_id} < LIMIT);

  // id found in the word under evaluation and the pointer just past it
  assign found16 = 16'({word_r, scan_res.bit_idx});
  assign next16  = found16 + 16'd1;

  assign gid_onehot = WORD_W'(1) << gid_r[BIT_W-1:0];
  assign gid_was    = gid_ok_r && rd_data[gid_r[BIT_W-1:0]];
  assign word_inc   = (word_r == WIW'(NW - 1)) ? '0 : word_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    gid_nxt       = gid_r;
    gid_ok_nxt    = gid_ok_r;
    sb_nxt        = sb_r;
    step_nxt      = step_r;
    word_nxt      = word_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_id_nxt    = out_id_r;
    out_full_nxt  = out_full_r;
    out_was_nxt   = out_was_r;
    rd_en         = 1'b0;
    rd_addr       = word_r;
    wr_en         = 1'b0;
    wr_addr       = word_r;
    wr_data       = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt   = in_mode;
          gid_nxt    = in_given_id;
          gid_ok_nxt = in_gid_ok;
          step_nxt   = '0;
          if (in_mode == MODE_ALLOC) begin
            // first word of the circular search
            sb_nxt    = start_id[BIT_W-1:0];
            word_nxt  = start16[BIT_W +: WIW];
            rd_en     = 1'b1;
            rd_addr   = start16[BIT_W +: WIW];
            state_nxt = S_SCAN;
          end else begin
            // out-of-range ids skip the read and read as free
            rd_en     = in_gid_ok;
            rd_addr   = gid16_in[BIT_W +: WIW];
            state_nxt = S_GID;
          end
        end
      end

      S_SCAN: begin
        // word_r's data is on rd_data; fetch the following word meanwhile
        rd_en    = 1'b1;
        rd_addr  = word_inc;
        word_nxt = word_inc;
        step_nxt = step_r + 1'b1;
        if (scan_res.found) begin
          wr_en         = 1'b1;
          wr_addr       = word_r;
          wr_data       = rd_data | (WORD_W'(1) << scan_res.bit_idx);
          ptr_nxt       = (next16 == 16'(NUM_IDS)) ? '0 : next16[ID_W-1:0];
          count_nxt     = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
          out_id_nxt    = found16[ID_W-1:0];
          out_full_nxt  = 1'b0;
          out_was_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (step_r == STEP_W'(NW)) begin
          // every id visited once, nothing free
          out_id_nxt    = '0;
          out_full_nxt  = 1'b1;
          out_was_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_GID: begin
        wr_addr = gid16_r[BIT_W +: WIW];
        if (mode_r == MODE_TAKE && gid_ok_r && !gid_was) begin
          wr_en     = 1'b1;
          wr_data   = rd_data | gid_onehot;
          count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
        end else if (mode_r == MODE_RELEASE && gid_was) begin
          wr_en     = 1'b1;
          wr_data   = rd_data & ~gid_onehot;
          count_nxt = (count_r == '0) ? count_r : count_r - 1'b1;
        end
        out_id_nxt    = '0;
        out_full_nxt  = 1'b0;
        out_was_nxt   = gid_was;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // per-item working registers and result payload
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    gid_r      <= gid_nxt;
    gid_ok_r   <= gid_ok_nxt;
    sb_r       <= sb_nxt;
    step_r     <= step_nxt;
    word_r     <= word_nxt;
    out_id_r   <= out_id_nxt;
    out_full_r <= out_full_nxt;
    out_was_r  <= out_was_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_allocated_id = out_id_r;
  assign out_pool_full    = out_full_r;
  assign out_id_was_taken = out_was_r;
  assign out_used_count   = count_r;

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for rotating_id_bitmap_allocator, random
// and directed allocate/take/release/check beats against a next-fit predictor.
// depends on idba_pkg and the allocator rtl only.
`timescale 1ns / 1ps

module testbench;
  import idba_pkg::*;

  // cycles with no request taken before the run is declared hung
  localparam int QUIET_LIMIT = 3000;
  // settle time after the last result
  localparam int TAIL_CYCLES = 24;
  localparam int TOTAL_ITEMS = 1950;
  localparam int REPORT_MAX  = 10;

  // one request as queued for the driver
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   gid;
    int                gap;    // idle cycles before start goes high
    bit                drain;  // hold off until all results are back
  } id_request_t;

  // one result beat as predicted
  typedef struct packed {
    logic [ID_W-1:0]    alloc_id;
    logic               pool_full;
    logic               was_taken;
    logic [COUNT_W-1:0] count;
  } id_result_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic [MODE_W-1:0]  in_mode     = MODE_CHECK;
  logic [ID_W-1:0]    in_given_id = '0;
  logic               out_valid;
  logic [ID_W-1:0]    out_allocated_id;
  logic               out_pool_full;
  logic               out_id_was_taken;
  logic [COUNT_W-1:0] out_used_count;

  rotating_id_bitmap_allocator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_given_id     (in_given_id),
    .out_valid       (out_valid),
    .out_allocated_id(out_allocated_id),
    .out_pool_full   (out_pool_full),
    .out_id_was_taken(out_id_was_taken),
    .out_used_count  (out_used_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // predictor state: in-use bitmap, next-fit pointer and in-use count
  // ---------------------------------------------------------------------
  bit [NUM_IDS_DEF-1:0] id_in_use;
  logic [ID_W-1:0]      search_ptr;
  logic [COUNT_W-1:0]   used_total;

  id_request_t pending_requests[$];
  id_result_t  results_due[$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  bit  took_beat      = 1'b0;

  // works out the result of one request and moves the predictor state on
  function automatic id_result_t next_fit_result(logic [MODE_W-1:0] mode,
                                                 logic [ID_W-1:0] gid);
    id_result_t      r;
    logic [ID_W-1:0] idx;
    bit              found;
    int              k;
    r = '0;
    found = 1'b0;
    if (mode == MODE_ALLOC) begin
      // circular scan from the pointer, the 8-bit index wraps by itself
      for (k = 0; k < NUM_IDS_DEF; k++) begin
        idx = search_ptr + 8'(k);
        if (!found && !id_in_use[idx]) begin
          found = 1'b1;
          id_in_use[idx] = 1'b1;
          if (used_total != COUNT_MAX) used_total++;
          r.alloc_id = idx;
          search_ptr = idx + 8'd1;
        end
      end
      // full pool leaves everything alone
      r.pool_full = !found;
    end else begin
      r.was_taken = id_in_use[gid];
      if (mode == MODE_TAKE && !r.was_taken) begin
        id_in_use[gid] = 1'b1;
        if (used_total != COUNT_MAX) used_total++;
      end else if (mode == MODE_RELEASE && r.was_taken) begin
        id_in_use[gid] = 1'b0;
        if (used_total != '0) used_total--;
      end
      // redundant take or release falls through with no change
    end
    r.count = used_total;
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch %0s at %0t: expected %0d, got %0d", what, $realtime, want, got);
  endtask

  // ---------------------------------------------------------------------
  // monitor: checks result beats and logs accepted requests, rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    id_result_t want;
    took_beat = 1'b0;
    if (rst_n) begin
      // check before logging, so a request taken on the same edge as a
      // result never gets compared against that result
      if (out_valid) begin
        if (results_due.size() == 0) begin
          note_mismatch("unexpected beat, used_count", 0, out_used_count);
        end else begin
          want = results_due.pop_front();
          if (out_allocated_id !== want.alloc_id)
            note_mismatch("allocated_id", want.alloc_id, out_allocated_id);
          if (out_pool_full !== want.pool_full)
            note_mismatch("pool_full", want.pool_full, out_pool_full);
          if (out_id_was_taken !== want.was_taken)
            note_mismatch("id_was_taken", want.was_taken, out_id_was_taken);
          if (out_used_count !== want.count)
            note_mismatch("used_count", want.count, out_used_count);
        end
      end
      if (start && !busy) begin
        took_beat = 1'b1;
        results_due.push_back(next_fit_result(in_mode, in_given_id));
      end
      // watchdog: only a taken request resets the quiet counter, so a
      // stuck result strobe cannot keep the run alive
      if (took_beat) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // ---------------------------------------------------------------------
  // driver: feeds pending requests, changes inputs on the falling edge
  // ---------------------------------------------------------------------
  id_request_t cur_req;
  bit          have_req = 1'b0;
  int          gap_left = 0;

  always @(negedge clk) begin
    // a raised start holds until the monitor saw it taken
    if (rst_n && !(start && !took_beat)) begin
      if (!have_req && pending_requests.size() > 0) begin
        cur_req  = pending_requests.pop_front();
        have_req = 1'b1;
        gap_left = cur_req.gap;
      end
      if (have_req && cur_req.drain && results_due.size() != 0) begin
        start <= 1'b0;
      end else if (have_req && gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (have_req) begin
        // back-to-back requests keep start high with a single update
        start       <= 1'b1;
        in_mode     <= cur_req.mode;
        in_given_id <= cur_req.gid;
        have_req = 1'b0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  task automatic queue_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] gid,
                               int gap, bit drain);
    id_request_t r;
    r.mode  = mode;
    r.gid   = gid;
    r.gap   = gap;
    r.drain = drain;
    pending_requests.push_back(r);
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // operation mix by segment flavor:
  // 0 fill the pool, 1 allocate heavy, 2 release heavy, 3 uniform
  function automatic logic [MODE_W-1:0] pick_mode(int flavor);
    int roll;
    roll = $urandom_range(0, 99);
    case (flavor)
      0: begin
        return (roll < 90) ? MODE_ALLOC : MODE_CHECK;
      end
      1: begin
        if (roll < 60) return MODE_ALLOC;
        if (roll < 75) return MODE_TAKE;
        if (roll < 90) return MODE_RELEASE;
        return MODE_CHECK;
      end
      2: begin
        if (roll < 10) return MODE_ALLOC;
        if (roll < 20) return MODE_TAKE;
        if (roll < 85) return MODE_RELEASE;
        return MODE_CHECK;
      end
      default: begin
        return MODE_W'($urandom_range(0, 3));
      end
    endcase
  endfunction

  task automatic build_stimulus();
    int queued;
    int seg_len;
    int flavor;
    bit no_idle;
    int i;
    // directed: extremes of the id, every operation, redundant take and
    // release, next-fit skipping a taken id and not reusing a freed one
    queue_request(MODE_CHECK,   8'd0,   0, 1'b0);
    queue_request(MODE_CHECK,   8'd255, 0, 1'b0);
    queue_request(MODE_ALLOC,   8'd255, 0, 1'b0);  // gets 0, id ignored
    queue_request(MODE_ALLOC,   8'd0,   2, 1'b0);  // gets 1
    queue_request(MODE_TAKE,    8'd255, 0, 1'b0);
    queue_request(MODE_TAKE,    8'd255, 0, 1'b0);  // already taken
    queue_request(MODE_CHECK,   8'd255, 0, 1'b0);
    queue_request(MODE_RELEASE, 8'd255, 5, 1'b0);
    queue_request(MODE_RELEASE, 8'd255, 0, 1'b0);  // already free
    queue_request(MODE_TAKE,    8'd2,   0, 1'b0);
    queue_request(MODE_ALLOC,   8'd0,   0, 1'b1);  // skips 2, gets 3
    queue_request(MODE_RELEASE, 8'd0,   0, 1'b0);
    queue_request(MODE_ALLOC,   8'd0,   0, 1'b0);  // next fit: 4, not 0
    queue_request(MODE_CHECK,   8'd0,   1, 1'b0);
    queue_request(MODE_CHECK,   8'd3,   0, 1'b0);
    queue_request(MODE_TAKE,    8'd170, 0, 1'b0);
    queue_request(MODE_TAKE,    8'd85,  0, 1'b0);
    queue_request(MODE_RELEASE, 8'd170, 0, 1'b1);
    queue_request(MODE_CHECK,   8'd85,  0, 1'b0);
    queued = 19;
    // random segments; the first one fills the pool so that wrap and full
    // pool show up early, later ones drain and refill it
    flavor  = 0;
    seg_len = 320;
    while (queued < TOTAL_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (i = 0; i < seg_len && queued < TOTAL_ITEMS; i++) begin
        queue_request(pick_mode(flavor), ID_W'($urandom_range(0, 255)),
                      pick_gap(no_idle), (i == 0) && $urandom_range(0, 1));
        queued++;
      end
      flavor  = $urandom_range(0, 3);
      seg_len = $urandom_range(50, 250);
    end
  endtask

  // ---------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------
  initial begin
    bit timed_out;
    bit drained;
    timed_out  = 1'b0;
    drained    = 1'b0;
    id_in_use  = '0;
    search_ptr = '0;
    used_total = '0;
    build_stimulus();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // wait for the last request to go in and every result to come back
    while (!drained && !timed_out) begin
      @(negedge clk);
      drained = pending_requests.size() == 0 && !have_req && !start &&
                results_due.size() == 0;
      timed_out = quiet_cycles >= QUIET_LIMIT;
    end
    // any stray beat after the end still gets flagged by the monitor
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);
    if (!timed_out && mismatch_count == 0 && results_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
